/* hdl/seird_pkg.sv */
// shared types, constants and arithmetic helpers for the seasonal seir derivative block
package seird_pkg;

    // operand and result widths
    localparam int CNT_W        = 32;
    localparam int OUT_W        = 40;
    localparam int DIFF_W       = 66;

    // pipelined long division lengths (bit steps)
    localparam int DIV1_STEPS   = 64;
    localparam int DIV2_STEPS   = 62;
    localparam int INF_TOP_W    = 20;
    localparam int PROD_W       = 98;
    localparam int SCALED_W     = PROD_W - 16;

    // cordic
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;

    typedef logic signed [CORDIC_W-1:0] t_cordic;

    localparam t_cordic CORDIC_GAIN = 34'sd652032874;

    // radians to turns, unsigned q0.32
    localparam logic [29:0] INV_TWO_PI = 30'd683565276;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_CONTACT_RATE_MEAN = 3'd0,
        REG_FORCING_AMPLITUDE = 3'd1,
        REG_FORCING_PERIOD    = 3'd2,
        REG_FORCING_PHASE     = 3'd3,
        REG_BIRTH_DEATH_RATE  = 3'd4,
        REG_INCUBATION_RATE   = 3'd5,
        REG_RECOVERY_RATE     = 3'd6,
        REG_POPULATION_SIZE   = 3'd7
    } t_cfg_reg;

    // arctangent table in q0.32 turns
    function automatic t_cordic atan_turns(input logic [3:0] idx);
        t_cordic a;
        case (idx)
            4'd0:    a = 34'sd536870912;
            4'd1:    a = 34'sd316933406;
            4'd2:    a = 34'sd167458907;
            4'd3:    a = 34'sd85004756;
            4'd4:    a = 34'sd42667331;
            4'd5:    a = 34'sd21354465;
            4'd6:    a = 34'sd10679838;
            4'd7:    a = 34'sd5340245;
            4'd8:    a = 34'sd2670163;
            4'd9:    a = 34'sd1335087;
            4'd10:   a = 34'sd667544;
            4'd11:   a = 34'sd333772;
            4'd12:   a = 34'sd166886;
            4'd13:   a = 34'sd83443;
            4'd14:   a = 34'sd41722;
            default: a = 34'sd20861;
        endcase
        return a;
    endfunction

    // one restoring division step: returns {quotient bit, new remainder}
    function automatic logic [CNT_W:0] div_step(input logic [CNT_W-1:0] rem,
                                                input logic b,
                                                input logic [CNT_W-1:0] d);
        logic [CNT_W:0] sh;
        logic [CNT_W:0] diff;
        sh   = {rem, b};
        diff = sh - {1'b0, d};
        if (sh >= {1'b0, d}) begin
            return {1'b1, diff[CNT_W-1:0]};
        end else begin
            return {1'b0, sh[CNT_W-1:0]};
        end
    endfunction

endpackage

/* hdl/seird_cordic.sv */
// pipelined cordic cosine, one rotation per stage, result negated on fold
module seird_cordic (
    input  logic              i_clk,
    input  seird_pkg::t_cordic i_angle,
    input  logic              i_fold,
    output seird_pkg::t_cordic o_cos
);
    import seird_pkg::*;

    t_cordic r_x    [0:CORDIC_STEPS];
    t_cordic r_y    [0:CORDIC_STEPS];
    t_cordic r_z    [0:CORDIC_STEPS];
    logic    r_fold [0:CORDIC_STEPS];
    t_cordic r_cos;

    // rotation stages
    always_ff @(posedge i_clk) begin
        r_x[0]    <= CORDIC_GAIN;
        r_y[0]    <= '0;
        r_z[0]    <= i_angle;
        r_fold[0] <= i_fold;
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            r_fold[k+1] <= r_fold[k];
            if (!r_z[k][CORDIC_W-1]) begin
                r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] - atan_turns(4'(k));
            end else begin
                r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] + atan_turns(4'(k));
            end
        end
        r_cos <= r_fold[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
    end

    assign o_cos = r_cos;

endmodule

/* hdl/seasonal_seir_derivative.sv */
// seasonally forced seir right-hand side, fully pipelined
//
// Usage: raise i_start with time, susceptible, exposed and infected counts;
// the request is taken whenever i_start is high and o_busy is low, and o_busy
// never rises, so a new point can be issued every clock cycle.
// Each result (three derivatives and the saturated flag) appears on the
// output ports for exactly one cycle with o_done high, in request order.
// The receiver cannot hold results off and the pipeline never stalls.
// Pipeline depth is set by the two bit-per-stage long dividers (64 steps for
// the time/period ratio, 62 for the infection term) and the 16-stage cordic.
// Throughput: one point per cycle.
// Configuration: a write on i_cfg_valid (o_cfg_ready always high) sets the
// register given by i_cfg_index; write only while no request is in flight.
// Reset (synchronous, active low) empties the pipeline and loads the
// register defaults.
module seasonal_seir_derivative (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [seird_pkg::CNT_W-1:0]     i_time_point,
    input  logic [seird_pkg::CNT_W-1:0]     i_susceptible,
    input  logic [seird_pkg::CNT_W-1:0]     i_exposed,
    input  logic [seird_pkg::CNT_W-1:0]     i_infected,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [2:0]                      i_cfg_index,
    input  logic [31:0]                     i_cfg_data,
    output logic                            o_done,
    output logic signed [seird_pkg::OUT_W-1:0] o_d_susceptible,
    output logic signed [seird_pkg::OUT_W-1:0] o_d_exposed,
    output logic signed [seird_pkg::OUT_W-1:0] o_d_infected,
    output logic                            o_saturated
);
    import seird_pkg::*;

    // stage positions
    localparam int ST_RATIO = DIV1_STEPS;
    localparam int ST_COS   = ST_RATIO + CORDIC_LAT;
    localparam int ST_F     = ST_COS + 1;
    localparam int ST_BPROD = ST_F + 1;
    localparam int ST_PP    = ST_BPROD + 1;
    localparam int ST_SUM   = ST_PP + 1;
    localparam int ST_PREP  = ST_SUM + 1;
    localparam int ST_QUOT  = ST_PREP + DIV2_STEPS;
    localparam int ST_LIN   = ST_QUOT + 1;
    localparam int ST_DIFF  = ST_LIN + 1;
    localparam int ST_OUT   = ST_DIFF + 1;

    localparam logic signed [DIFF_W-1:0] CLIP_MAX = 66'sh7F_FFFF_FFFF;
    localparam logic signed [DIFF_W-1:0] CLIP_MIN = -66'sh80_0000_0000;
    localparam logic [31:0]              SIR_MARK = 32'hFFFF_FFFF;

    // configuration registers
    logic [31:0]        r_contact_rate_mean;
    logic [15:0]        r_forcing_amplitude;
    logic [31:0]        r_forcing_period;
    logic signed [19:0] r_forcing_phase;
    logic [31:0]        r_birth_death_rate;
    logic [31:0]        r_incubation_rate;
    logic [31:0]        r_recovery_rate;
    logic [31:0]        r_population_size;

    // values derived from configuration
    logic [31:0] r_phi_turns;
    logic [39:0] r_nmu;
    logic [31:0] pop_n;
    logic [31:0] per_n;
    logic        sir_mode;

    // pipeline control and carried counts
    logic              r_vld [0:ST_OUT];
    logic [CNT_W-1:0]  r_s   [0:ST_QUOT];
    logic [CNT_W-1:0]  r_e   [0:ST_QUOT];
    logic [CNT_W-1:0]  r_i   [0:ST_QUOT];

    // time/period divider
    logic [CNT_W-1:0]  r_d1_rem [0:DIV1_STEPS];
    logic [CNT_W-1:0]  r_d1_t   [0:DIV1_STEPS];
    logic [CNT_W-1:0]  r_d1_q   [0:DIV1_STEPS];
    logic [CNT_W:0]    d1_step  [0:DIV1_STEPS-1];

    // phase and cosine
    logic [31:0] phase;
    logic [31:0] phase_q;
    logic        fold;
    logic [31:0] fold_w;
    t_cordic     angle;
    t_cordic     cos_q;

    // contact rate
    logic signed [50:0] f_prod;
    logic signed [35:0] f_sum;
    logic [31:0]        r_f;
    logic [63:0]        r_bfull;
    logic [63:0]        r_si;
    logic [33:0]        beta;
    logic [48:0]        r_pp_ll;
    logic [48:0]        r_pp_lh;
    logic [48:0]        r_pp_hl;
    logic [48:0]        r_pp_hh;
    logic [PROD_W-1:0]  prod_sum;
    logic [SCALED_W-1:0] r_scaled;

    // infection divider
    logic                         r_d2_over [0:DIV2_STEPS];
    logic [CNT_W-1:0]             r_d2_rem  [0:DIV2_STEPS];
    logic [DIV2_STEPS-1:0]        r_d2_low  [0:DIV2_STEPS];
    logic [DIV2_STEPS-1:0]        r_d2_q    [0:DIV2_STEPS];
    logic [CNT_W:0]               d2_step   [0:DIV2_STEPS-1];
    logic [INF_TOP_W-1:0]         inf_top;

    // linear terms and sums
    logic [62:0]                 r_inf;
    logic [39:0]                 r_mus;
    logic [39:0]                 r_mue;
    logic [39:0]                 r_mui;
    logic [39:0]                 r_sige;
    logic [39:0]                 r_gami;
    logic signed [DIFF_W-1:0]    r_ds;
    logic signed [DIFF_W-1:0]    r_de;
    logic signed [DIFF_W-1:0]    r_di;
    logic signed [OUT_W-1:0]     r_out_ds;
    logic signed [OUT_W-1:0]     r_out_de;
    logic signed [OUT_W-1:0]     r_out_di;
    logic                        r_out_sat;
    logic [OUT_W:0]              clip_s;
    logic [OUT_W:0]              clip_e;
    logic [OUT_W:0]              clip_i;

    // phi conversion helpers
    logic [19:0] ph_abs;
    logic [49:0] ph_mag;
    logic [34:0] ph_rnd;

    // saturate to 40 bits, returns {clipped, value}
    function automatic logic [OUT_W:0] clip40(input logic signed [DIFF_W-1:0] v);
        if (v > CLIP_MAX) begin
            return {1'b1, CLIP_MAX[OUT_W-1:0]};
        end else if (v < CLIP_MIN) begin
            return {1'b1, CLIP_MIN[OUT_W-1:0]};
        end else begin
            return {1'b0, v[OUT_W-1:0]};
        end
    endfunction

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    assign pop_n    = (r_population_size == '0) ? 32'd1 : r_population_size;
    assign per_n    = (r_forcing_period == '0) ? 32'd1 : r_forcing_period;
    assign sir_mode = (r_incubation_rate == SIR_MARK);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_contact_rate_mean <= 32'd65536000;
            r_forcing_amplitude <= 16'd6554;
            r_forcing_period    <= 32'd65536;
            r_forcing_phase     <= '0;
            r_birth_death_rate  <= 32'd335544;
            r_incubation_rate   <= 32'd765460480;
            r_recovery_rate     <= 32'd1224736768;
            r_population_size   <= 32'd256000000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_CONTACT_RATE_MEAN: r_contact_rate_mean <= i_cfg_data;
                REG_FORCING_AMPLITUDE: r_forcing_amplitude <= i_cfg_data[15:0];
                REG_FORCING_PERIOD:    r_forcing_period    <= i_cfg_data;
                REG_FORCING_PHASE:     r_forcing_phase     <= $signed(i_cfg_data[19:0]);
                REG_BIRTH_DEATH_RATE:  r_birth_death_rate  <= i_cfg_data;
                REG_INCUBATION_RATE:   r_incubation_rate   <= i_cfg_data;
                REG_RECOVERY_RATE:     r_recovery_rate     <= i_cfg_data;
                REG_POPULATION_SIZE:   r_population_size   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // phase offset in turns, rounded half away from zero
    always_comb begin
        ph_abs = r_forcing_phase[19] ? 20'(-r_forcing_phase) : 20'(r_forcing_phase);
        ph_mag = 50'(ph_abs) * 50'(INV_TWO_PI);
        ph_rnd = 35'((ph_mag + 50'd32768) >> 16);
    end

    // slow-changing products of configuration
    always_ff @(posedge i_clk) begin
        r_phi_turns <= r_forcing_phase[19] ? 32'(-ph_rnd) : ph_rnd[31:0];
        r_nmu       <= 40'((64'(r_birth_death_rate) * 64'(pop_n)) >> 24);
    end

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ST_OUT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_start && !o_busy;
            for (int k = 0; k < ST_OUT; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    // request capture and carried counts
    always_ff @(posedge i_clk) begin
        r_s[0] <= i_susceptible;
        r_e[0] <= i_exposed;
        r_i[0] <= i_infected;
        for (int k = 0; k < ST_QUOT; k++) begin
            r_s[k+1] <= r_s[k];
            r_e[k+1] <= r_e[k];
            r_i[k+1] <= r_i[k];
        end
    end

    // time/period divider step results
    always_comb begin
        for (int k = 0; k < DIV1_STEPS; k++) begin
            d1_step[k] = div_step(r_d1_rem[k], r_d1_t[k][CNT_W-1], per_n);
        end
    end

    // time/period divider, low 32 quotient bits of t*2^32/T
    always_ff @(posedge i_clk) begin
        r_d1_rem[0] <= '0;
        r_d1_t[0]   <= i_time_point;
        r_d1_q[0]   <= '0;
        for (int k = 0; k < DIV1_STEPS; k++) begin
            r_d1_rem[k+1] <= d1_step[k][CNT_W-1:0];
            r_d1_q[k+1]   <= {r_d1_q[k][CNT_W-2:0], d1_step[k][CNT_W]};
            r_d1_t[k+1]   <= {r_d1_t[k][CNT_W-2:0], 1'b0};
        end
    end

    // phase sum and half-turn fold
    always_comb begin
        phase   = r_d1_q[ST_RATIO] + r_phi_turns;
        phase_q = phase + 32'h4000_0000;
        fold    = phase_q[31];
        fold_w  = {phase[31] ^ fold, phase[30:0]};
        angle   = CORDIC_W'($signed(fold_w));
    end

    seird_cordic u_cordic (
        .i_clk   (i_clk),
        .i_angle (angle),
        .i_fold  (fold),
        .o_cos   (cos_q)
    );

    // seasonal factor, clamped at zero
    always_comb begin
        f_prod = $signed({1'b0, r_forcing_amplitude}) * cos_q;
        f_sum  = 36'(f_prod >>> 16) + 36'sd1073741824;
    end

    // contact rate and infection product
    always_ff @(posedge i_clk) begin
        r_f     <= f_sum[35] ? '0 : f_sum[31:0];
        r_bfull <= 64'(r_contact_rate_mean) * 64'(r_f);
        r_si    <= 64'(r_s[ST_F]) * 64'(r_i[ST_F]);
        r_pp_ll <= 49'(r_si[31:0])  * 49'(beta[16:0]);
        r_pp_lh <= 49'(r_si[31:0])  * 49'(beta[33:17]);
        r_pp_hl <= 49'(r_si[63:32]) * 49'(beta[16:0]);
        r_pp_hh <= 49'(r_si[63:32]) * 49'(beta[33:17]);
        r_scaled <= prod_sum[PROD_W-1:16];
    end

    assign beta     = r_bfull[63:30];
    assign prod_sum = PROD_W'(r_pp_ll) + (PROD_W'(r_pp_lh) << 17)
                    + (PROD_W'(r_pp_hl) << 32) + (PROD_W'(r_pp_hh) << 49);
    assign inf_top  = r_scaled[SCALED_W-1:DIV2_STEPS];

    // infection divider step results
    always_comb begin
        for (int k = 0; k < DIV2_STEPS; k++) begin
            d2_step[k] = div_step(r_d2_rem[k], r_d2_low[k][DIV2_STEPS-1], pop_n);
        end
    end

    // infection divider by n, capped when the quotient reaches 2^62
    always_ff @(posedge i_clk) begin
        r_d2_over[0] <= (32'(inf_top) >= pop_n);
        r_d2_rem[0]  <= (32'(inf_top) >= pop_n) ? '0 : 32'(inf_top);
        r_d2_low[0]  <= r_scaled[DIV2_STEPS-1:0];
        r_d2_q[0]    <= '0;
        for (int k = 0; k < DIV2_STEPS; k++) begin
            r_d2_over[k+1] <= r_d2_over[k];
            r_d2_rem[k+1]  <= d2_step[k][CNT_W-1:0];
            r_d2_q[k+1]    <= {r_d2_q[k][DIV2_STEPS-2:0], d2_step[k][CNT_W]};
            r_d2_low[k+1]  <= {r_d2_low[k][DIV2_STEPS-2:0], 1'b0};
        end
    end

    // linear rate terms
    always_ff @(posedge i_clk) begin
        r_inf  <= r_d2_over[DIV2_STEPS] ? {1'b1, 62'd0} : {1'b0, r_d2_q[DIV2_STEPS]};
        r_mus  <= 40'((64'(r_birth_death_rate) * 64'(r_s[ST_QUOT])) >> 24);
        r_mue  <= 40'((64'(r_birth_death_rate) * 64'(r_e[ST_QUOT])) >> 24);
        r_mui  <= 40'((64'(r_birth_death_rate) * 64'(r_i[ST_QUOT])) >> 24);
        r_sige <= 40'((64'(r_incubation_rate) * 64'(r_e[ST_QUOT])) >> 24);
        r_gami <= 40'((64'(r_recovery_rate) * 64'(r_i[ST_QUOT])) >> 24);
    end

    // derivative sums
    always_ff @(posedge i_clk) begin
        r_ds <= $signed(DIFF_W'(r_nmu)) - $signed(DIFF_W'(r_inf))
              - $signed(DIFF_W'(r_mus));
        if (sir_mode) begin
            r_de <= '0;
            r_di <= $signed(DIFF_W'(r_inf)) - $signed(DIFF_W'(r_gami))
                  - $signed(DIFF_W'(r_mui));
        end else begin
            r_de <= $signed(DIFF_W'(r_inf)) - $signed(DIFF_W'(r_sige))
                  - $signed(DIFF_W'(r_mue));
            r_di <= $signed(DIFF_W'(r_sige)) - $signed(DIFF_W'(r_gami))
                  - $signed(DIFF_W'(r_mui));
        end
    end

    // output saturation
    assign clip_s = clip40(r_ds);
    assign clip_e = clip40(r_de);
    assign clip_i = clip40(r_di);

    always_ff @(posedge i_clk) begin
        r_out_ds  <= $signed(clip_s[OUT_W-1:0]);
        r_out_de  <= $signed(clip_e[OUT_W-1:0]);
        r_out_di  <= $signed(clip_i[OUT_W-1:0]);
        r_out_sat <= clip_s[OUT_W] | clip_e[OUT_W] | clip_i[OUT_W];
    end

    assign o_done          = r_vld[ST_OUT];
    assign o_d_susceptible = r_out_ds;
    assign o_d_exposed     = r_out_de;
    assign o_d_infected    = r_out_di;
    assign o_saturated     = r_out_sat;

endmodule
